>>> rtl/tlfs_pkg.sv
// Shared types and constants for the target-lock follow steering block.
// No dependencies; imported by tlfs_decide and target_lock_follow_steering.
package tlfs_pkg;

  localparam int unsigned XW   = 16;   // lateral offset, signed, 1/1024 m
  localparam int unsigned DW   = 17;   // distance, 1/1024 m
  localparam int unsigned IDW  = 16;
  localparam int unsigned THRW = 15;
  localparam int unsigned HW   = 8;    // hold_frames and missed_frames
  localparam int unsigned CIW  = 3;    // configuration index
  localparam int unsigned CDW  = 17;   // configuration data

  localparam logic [DW-1:0] NO_TARGET_DIST = DW'(102400);
  localparam logic [HW-1:0] MISSED_MAX     = '1;

  typedef enum logic [CIW-1:0] {
    REG_TURN_THRESHOLD = 3'd0,
    REG_NEAR_LIMIT     = 3'd1,
    REG_FOLLOW_LOW     = 3'd2,
    REG_FOLLOW_HIGH    = 3'd3,
    REG_HOLD_FRAMES    = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    CMD_TURN_RIGHT = 3'd0,
    CMD_TURN_LEFT  = 3'd1,
    CMD_FORWARD    = 3'd2,
    CMD_BACKWARD   = 3'd3,
    CMD_STOP       = 3'd4
  } drive_cmd_t;

  typedef struct packed {
    logic [THRW-1:0] turn_threshold;
    logic [DW-1:0]   near_limit;
    logic [DW-1:0]   follow_low;
    logic [DW-1:0]   follow_high;
  } thresholds_t;

  localparam logic [THRW-1:0] TURN_THRESHOLD_RST = THRW'(410);
  localparam logic [DW-1:0]   NEAR_LIMIT_RST     = DW'(2355);
  localparam logic [DW-1:0]   FOLLOW_LOW_RST     = DW'(2662);
  localparam logic [DW-1:0]   FOLLOW_HIGH_RST    = DW'(10240);
  localparam logic [HW-1:0]   HOLD_FRAMES_RST    = HW'(1);

endpackage

>>> rtl/target_lock_follow_steering.sv
// Top level of the target-lock follow steering block.
// Depends on tlfs_pkg and tlfs_decide.
//
// Takes one item per clock: track items update the running nearest track and
// the lock in the cycle they transfer, and an end-of-frame item forms the
// drive command in that same cycle and places it in the output register, where
// it shows in the next cycle. Track items are taken even while a result waits;
// only an end-of-frame item waits for the output register to free up, so a
// stalled consumer holds back at most the frame close. Configuration writes
// are taken at any time, one per cycle.
module target_lock_follow_steering (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [tlfs_pkg::IDW-1:0]          in_track_id,
  input  logic signed [tlfs_pkg::XW-1:0]    in_track_x,
  input  logic [tlfs_pkg::DW-1:0]           in_track_distance,
  input  logic                              in_track_visibility,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_drive_command,
  output logic signed [tlfs_pkg::XW-1:0]    out_chosen_x,
  output logic [tlfs_pkg::DW-1:0]           out_chosen_distance,
  output logic                              out_target_locked,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tlfs_pkg::CIW-1:0]          cfg_index,
  input  logic [tlfs_pkg::CDW-1:0]          cfg_data
);
  import tlfs_pkg::*;

  // configuration
  thresholds_t    thr_r;
  logic [HW-1:0]  hold_frames_r;

  // tracking state
  logic signed [XW-1:0] nearest_x_r,  nearest_x_nxt;
  logic [DW-1:0]        nearest_d_r,  nearest_d_nxt;
  logic                 lock_valid_r, lock_valid_nxt;
  logic [IDW-1:0]       locked_id_r,  locked_id_nxt;
  logic signed [XW-1:0] locked_x_r,   locked_x_nxt;
  logic [DW-1:0]        locked_d_r,   locked_d_nxt;
  logic                 began_unlocked_r, began_unlocked_nxt;
  logic                 seen_r,       seen_nxt;
  logic [HW-1:0]        missed_r,     missed_nxt;

  // output register
  logic                 out_valid_r,  out_valid_nxt;
  logic [2:0]           out_cmd_r;
  logic signed [XW-1:0] out_x_r;
  logic [DW-1:0]        out_d_r;
  logic                 out_locked_r;

  logic                 in_fire;
  logic                 eof_fire;
  logic                 trk_fire;
  logic                 eligible;
  logic                 take_nearest;
  logic                 follow_hit;
  logic                 active;
  logic                 use_locked;
  logic [HW-1:0]        missed_inc;
  logic                 drop_lock;
  logic signed [XW-1:0] cx;
  logic [DW-1:0]        cd;
  drive_cmd_t           cmd;

  assign in_ready  = !in_kind || !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign eof_fire  = in_fire && in_kind;
  assign trk_fire  = in_fire && !in_kind;
  assign cfg_ready = 1'b1;

  assign eligible     = !in_track_visibility;
  assign take_nearest = eligible && (in_track_distance < nearest_d_r);
  assign follow_hit   = !began_unlocked_r && lock_valid_r && eligible &&
                        (in_track_id == locked_id_r);

  // frame close
  assign active     = began_unlocked_r || seen_r;
  assign use_locked = (active || (missed_r < hold_frames_r)) && lock_valid_r;
  assign missed_inc = (!active && (missed_r != MISSED_MAX)) ? missed_r + HW'(1) : missed_r;
  assign drop_lock  = missed_inc >= hold_frames_r;
  assign cx         = use_locked ? locked_x_r : nearest_x_r;
  assign cd         = use_locked ? locked_d_r : nearest_d_r;

  tlfs_decide u_decide (
    .chosen_x        (cx),
    .chosen_distance (cd),
    .thr             (thr_r),
    .drive_command   (cmd)
  );

  always_comb begin
    nearest_x_nxt      = nearest_x_r;
    nearest_d_nxt      = nearest_d_r;
    lock_valid_nxt     = lock_valid_r;
    locked_id_nxt      = locked_id_r;
    locked_x_nxt       = locked_x_r;
    locked_d_nxt       = locked_d_r;
    began_unlocked_nxt = began_unlocked_r;
    seen_nxt           = seen_r;
    missed_nxt         = missed_r;
    if (trk_fire) begin
      if (take_nearest) begin
        nearest_x_nxt = in_track_x;
        nearest_d_nxt = in_track_distance;
        if (began_unlocked_r) begin
          locked_id_nxt  = in_track_id;
          locked_x_nxt   = in_track_x;
          locked_d_nxt   = in_track_distance;
          lock_valid_nxt = 1'b1;
        end
      end
      // only in a locked frame, so never overlaps the lock-on above
      if (follow_hit) begin
        locked_x_nxt = in_track_x;
        locked_d_nxt = in_track_distance;
        seen_nxt     = 1'b1;
        missed_nxt   = '0;
      end
    end else if (eof_fire) begin
      lock_valid_nxt     = drop_lock ? 1'b0 : lock_valid_r;
      missed_nxt         = drop_lock ? '0 : missed_inc;
      nearest_x_nxt      = '0;
      nearest_d_nxt      = NO_TARGET_DIST;
      seen_nxt           = 1'b0;
      began_unlocked_nxt = drop_lock || !lock_valid_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (eof_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.turn_threshold <= TURN_THRESHOLD_RST;
      thr_r.near_limit     <= NEAR_LIMIT_RST;
      thr_r.follow_low     <= FOLLOW_LOW_RST;
      thr_r.follow_high    <= FOLLOW_HIGH_RST;
      hold_frames_r        <= HOLD_FRAMES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TURN_THRESHOLD: thr_r.turn_threshold <= cfg_data[THRW-1:0];
        REG_NEAR_LIMIT:     thr_r.near_limit     <= cfg_data[DW-1:0];
        REG_FOLLOW_LOW:     thr_r.follow_low     <= cfg_data[DW-1:0];
        REG_FOLLOW_HIGH:    thr_r.follow_high    <= cfg_data[DW-1:0];
        REG_HOLD_FRAMES:    hold_frames_r        <= cfg_data[HW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nearest_x_r      <= '0;
      nearest_d_r      <= NO_TARGET_DIST;
      lock_valid_r     <= 1'b0;
      locked_id_r      <= '0;
      locked_x_r       <= '0;
      locked_d_r       <= '0;
      began_unlocked_r <= 1'b1;
      seen_r           <= 1'b0;
      missed_r         <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      nearest_x_r      <= nearest_x_nxt;
      nearest_d_r      <= nearest_d_nxt;
      lock_valid_r     <= lock_valid_nxt;
      locked_id_r      <= locked_id_nxt;
      locked_x_r       <= locked_x_nxt;
      locked_d_r       <= locked_d_nxt;
      began_unlocked_r <= began_unlocked_nxt;
      seen_r           <= seen_nxt;
      missed_r         <= missed_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (eof_fire) begin
      out_cmd_r    <= cmd;
      out_x_r      <= cx;
      out_d_r      <= cd;
      out_locked_r <= !drop_lock && lock_valid_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_drive_command   = out_cmd_r;
  assign out_chosen_x        = out_x_r;
  assign out_chosen_distance = out_d_r;
  assign out_target_locked   = out_locked_r;

`ifndef ASSERT_OFF
  a_unlocked_frame_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !lock_valid_r |-> began_unlocked_r)
    else $error("frame marked locked while no lock is held");

  a_seen_clears_missed: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (missed_r == '0))
    else $error("locked id seen but miss count not cleared");

  a_nearest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nearest_d_r <= NO_TARGET_DIST)
    else $error("nearest distance above no-target value");

  a_lock_on: assert property (@(posedge clk) disable iff (!rst_n)
    trk_fire && began_unlocked_r && take_nearest |=> lock_valid_r)
    else $error("unlocked frame failed to lock onto nearest track");

  a_eof_result: assert property (@(posedge clk) disable iff (!rst_n)
    eof_fire |=> out_valid_r)
    else $error("end of frame produced no result");
`endif

endmodule

>>> rtl/tlfs_decide.sv
// Drive command decision from the chosen offset and distance.
// Depends on tlfs_pkg for the threshold struct and command codes.
module tlfs_decide (
  input  logic signed [tlfs_pkg::XW-1:0] chosen_x,
  input  logic [tlfs_pkg::DW-1:0]        chosen_distance,
  input  tlfs_pkg::thresholds_t          thr,
  output tlfs_pkg::drive_cmd_t           drive_command
);
  import tlfs_pkg::*;

  logic signed [XW:0] x_ext;
  logic signed [XW:0] thr_pos;
  logic signed [XW:0] thr_neg;

  assign x_ext   = (XW+1)'(chosen_x);
  assign thr_pos = $signed({{(XW+1-THRW){1'b0}}, thr.turn_threshold});
  assign thr_neg = -thr_pos;

  // Priority: turning first, then the distance bands.
  always_comb begin
    if (x_ext > thr_pos) begin
      drive_command = CMD_TURN_RIGHT;
    end else if (x_ext < thr_neg) begin
      drive_command = CMD_TURN_LEFT;
    end else if (chosen_distance > thr.follow_low && chosen_distance < thr.follow_high) begin
      drive_command = CMD_FORWARD;
    end else if (chosen_distance < thr.near_limit) begin
      drive_command = CMD_BACKWARD;
    end else begin
      drive_command = CMD_STOP;
    end
  end

endmodule
